// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mie_pkg.sv -----
// types and constants of the mips1 integer execute block
`timescale 1ns / 1ps
package mie_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MDWAIT,
    ST_IDXWAIT,
    ST_MEMRD,
    ST_MEMWB,
    ST_DONE
  } mie_state_e;

  typedef struct packed {
    logic start;
    logic div;
    logic sgn;
  } md_req_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_ILL   = 2'd1,
    FAULT_ALIGN = 2'd2
  } fault_e;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_LWR     = 6'd38;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // special function codes
  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_SRAV  = 6'd7;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_JALR  = 6'd9;
  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MTHI  = 6'd17;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MTLO  = 6'd19;
  localparam logic [5:0] FN_MULT  = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV   = 6'd26;
  localparam logic [5:0] FN_DIVU  = 6'd27;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_NOR   = 6'd39;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  // regimm codes
  localparam logic [4:0] RI_BLTZ   = 5'd0;
  localparam logic [4:0] RI_BGEZ   = 5'd1;
  localparam logic [4:0] RI_BLTZAL = 5'd16;
  localparam logic [4:0] RI_BGEZAL = 5'd17;

  localparam logic [4:0]  LINK_REG  = 5'b11111;
  localparam logic [31:0] JUMP_MASK = 32'hF000_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

endpackage

// ----- design/mie_if.sv -----
// request channels of the mips1 integer execute block
`timescale 1ns / 1ps
interface mie_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface mie_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_fetch_addr;
  logic        reg_written;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic        store_done;
  logic [1:0]  fault_code;

  modport source (output valid, output next_fetch_addr, output reg_written,
                  output dest_index, output dest_value, output store_done,
                  output fault_code, input ready);
  modport sink (input valid, input next_fetch_addr, input reg_written,
                input dest_index, input dest_value, input store_done,
                input fault_code, output ready);
endinterface

// ----- design/mie_muldiv.sv -----
// iterative shift-add multiplier and restoring divider sharing one adder
`timescale 1ns / 1ps
module mie_muldiv import mie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  md_req_t     req_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] hi_o,
  output logic [31:0] lo_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] hi_q, lo_q, b_q, a_orig_q;
  logic        div_q, neg_q, rneg_q, zero_q;

  logic        na, nb;
  logic [33:0] opa, opb, sum;
  logic        ge;
  logic [63:0] prod, prod_neg;

  assign na = req_i.sgn & a_i[31];
  assign nb = req_i.sgn & b_i[31];

  // one adder: accumulate for multiply, trial subtract for divide
  assign opa = div_q ? {1'b0, hi_q, lo_q[31]} : {2'b00, hi_q};
  assign opb = div_q ? ~{2'b00, b_q} : {2'b00, (lo_q[0] ? b_q : 32'd0)};
  assign sum = opa + opb + {33'd0, div_q};
  assign ge  = ~sum[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q     <= '0;
      lo_q     <= na ? (32'd0 - a_i) : a_i;
      b_q      <= nb ? (32'd0 - b_i) : b_i;
      a_orig_q <= a_i;
      div_q    <= req_i.div;
      neg_q    <= na ^ nb;
      rneg_q   <= na;
      zero_q   <= req_i.div && (b_i == 32'd0);
    end else if (busy_q) begin
      if (div_q) begin
        hi_q <= ge ? sum[31:0] : {hi_q[30:0], lo_q[31]};
        lo_q <= {lo_q[30:0], ge};
      end else begin
        hi_q <= sum[32:1];
        lo_q <= {sum[0], lo_q[31:1]};
      end
    end
  end

  assign prod     = {hi_q, lo_q};
  assign prod_neg = 64'd0 - prod;

  always_comb begin
    if (!div_q) begin
      {hi_o, lo_o} = neg_q ? prod_neg : prod;
    end else if (zero_q) begin
      hi_o = a_orig_q;
      lo_o = ALL_ONES;
    end else begin
      hi_o = rneg_q ? (32'd0 - hi_q) : hi_q;
      lo_o = neg_q ? (32'd0 - lo_q) : lo_q;
    end
  end

  assign done_o = done_q;

endmodule

// ----- design/mips1_integer_execute_top.sv -----
// top level of the mips1 integer execute block
// channel  | dir | modport | payload
// in_i     | in  | sink    | instr_word
// res_o    | out | source  | next_fetch_addr, reg_written, dest_index, dest_value,
//          |     |         | store_done, fault_code
// states: alu, branch, jump and misaligned access go exec, done; load/store go exec,
//   memrd, memwb, done (with idxwait for the word index when DMEM_WORDS is not a power
//   of two); mult/div go exec, mdwait, done; each result waits in done until taken
// mult/div and the word index take 32 steps through the muldiv unit's one shared adder
// reset: rst_ni async active low; afterwards data memory is swept clear, one word
//   a cycle, with in_i.ready low (config writes still taken)
// one instruction at a time: in_i.ready only when idle, result held until taken
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mips1_integer_execute_top import mie_pkg::*; #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  mie_in_if.sink      in_i,
  mie_res_if.source   res_o
);

  localparam int  AW   = $clog2(DMEM_WORDS);
  localparam bit  POW2 = (DMEM_WORDS & (DMEM_WORDS - 1)) == 0;

  mie_state_e state_q, state_d;

  // architectural state
  logic [31:0] pc_q, hi_q, lo_q, bdest_q;
  logic        bpend_q;
  logic [31:0] rf [32];
  logic [31:0] rf_vld_q;
  logic [31:0] dmem [DMEM_WORDS];

  // per-instruction registers
  logic [31:0] ins_q, rfa_q, rfb_q, rdata_q;
  logic        vlda_q, vldb_q;
  logic [AW-1:0] idx_q;

  // clear sweep
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  // result register
  logic        ovld_q;
  logic [31:0] onpc_q, oval_q;
  logic        owr_q, ost_q;
  logic [4:0]  oreg_q;
  logic [1:0]  oflt_q;

  // decode fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] a, b, simm, zimm, seq, btgt, addr;
  logic [1:0]  lane;
  logic [4:0]  lsh;
  logic        in_acc, out_acc;

  // muldiv unit
  md_req_t     md_req;
  logic [31:0] md_a, md_b, md_hi, md_lo;
  logic        md_done;

  // control outputs of the decoder
  logic        is_md, is_mem, misal, fin;
  logic        wr, st, take, mthi, mtlo;
  logic [4:0]  wreg;
  logic [31:0] wval, tgt, st_data, st_mask, npc;
  fault_e      fault;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  assign op   = ins_q[31:26];
  assign rs   = ins_q[25:21];
  assign rt   = ins_q[20:16];
  assign rd   = ins_q[15:11];
  assign sa   = ins_q[10:6];
  assign fn   = ins_q[5:0];
  assign a    = vlda_q ? rfa_q : 32'd0;
  assign b    = vldb_q ? rfb_q : 32'd0;
  assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
  assign zimm = {16'd0, ins_q[15:0]};
  assign seq  = pc_q + 32'd4;
  assign btgt = seq + {simm[29:0], 2'b00};
  assign addr = a + simm;
  assign lane = addr[1:0];
  assign lsh  = {lane, 3'b000};

  mie_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .done_o (md_done),
    .hi_o   (md_hi),
    .lo_o   (md_lo)
  );

  // instruction class and alignment
  always_comb begin
    is_md  = (op == OP_SPECIAL) &&
             (fn == FN_MULT || fn == FN_MULTU || fn == FN_DIV || fn == FN_DIVU);
    is_mem = 1'b0;
    misal  = 1'b0;
    case (op)
      OP_LB, OP_LBU, OP_LWL, OP_LWR, OP_SB: is_mem = 1'b1;
      OP_LH, OP_LHU, OP_SH: begin
        is_mem = 1'b1;
        misal  = lane[0];
      end
      OP_LW, OP_SW: begin
        is_mem = 1'b1;
        misal  = (lane != 2'd0);
      end
      default: is_mem = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_EXEC;
      ST_EXEC: begin
        if (is_md) state_d = ST_MDWAIT;
        else if (is_mem && !misal) state_d = POW2 ? ST_MEMRD : ST_IDXWAIT;
        else state_d = ST_DONE;
      end
      ST_MDWAIT:  if (md_done) state_d = ST_DONE;
      ST_IDXWAIT: if (md_done) state_d = ST_MEMRD;
      ST_MEMRD:   state_d = ST_MEMWB;
      ST_MEMWB:   state_d = ST_DONE;
      ST_DONE:    if (out_acc) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // decode and result values
  always_comb begin
    wr    = 1'b0;
    wreg  = rd;
    wval  = 32'd0;
    st    = 1'b0;
    take  = 1'b0;
    tgt   = btgt;
    mthi  = 1'b0;
    mtlo  = 1'b0;
    fault = FAULT_NONE;
    st_mask = ALL_ONES;
    case (op)
      OP_SPECIAL: begin
        wr = 1'b1;
        case (fn)
          FN_SLL:  wval = b << sa;
          FN_SRL:  wval = b >> sa;
          FN_SRA:  wval = 32'($signed(b) >>> sa);
          FN_SLLV: wval = b << a[4:0];
          FN_SRLV: wval = b >> a[4:0];
          FN_SRAV: wval = 32'($signed(b) >>> a[4:0]);
          FN_JR: begin
            wr = 1'b0; take = 1'b1; tgt = a;
          end
          FN_JALR: begin
            wval = pc_q + 32'd8; take = 1'b1; tgt = a;
          end
          FN_MFHI: wval = hi_q;
          FN_MTHI: begin
            wr = 1'b0; mthi = 1'b1;
          end
          FN_MFLO: wval = lo_q;
          FN_MTLO: begin
            wr = 1'b0; mtlo = 1'b1;
          end
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: wr = 1'b0;
          FN_ADD, FN_ADDU: wval = a + b;
          FN_SUB, FN_SUBU: wval = a - b;
          FN_AND:  wval = a & b;
          FN_OR:   wval = a | b;
          FN_XOR:  wval = a ^ b;
          FN_NOR:  wval = ~(a | b);
          FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
          FN_SLTU: wval = {31'd0, a < b};
          default: begin
            wr = 1'b0; fault = FAULT_ILL;
          end
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RI_BLTZ: take = a[31];
          RI_BGEZ: take = ~a[31];
          RI_BLTZAL: begin
            take = a[31]; wr = 1'b1; wreg = LINK_REG; wval = pc_q + 32'd8;
          end
          RI_BGEZAL: begin
            take = ~a[31]; wr = 1'b1; wreg = LINK_REG; wval = pc_q + 32'd8;
          end
          default: fault = FAULT_ILL;
        endcase
      end
      OP_J: begin
        take = 1'b1;
        tgt  = (seq & JUMP_MASK) | {4'd0, ins_q[25:0], 2'b00};
      end
      OP_JAL: begin
        take = 1'b1;
        tgt  = (seq & JUMP_MASK) | {4'd0, ins_q[25:0], 2'b00};
        wr = 1'b1; wreg = LINK_REG; wval = pc_q + 32'd8;
      end
      OP_BEQ:  take = (a == b);
      OP_BNE:  take = (a != b);
      OP_BLEZ: take = a[31] || (a == 32'd0);
      OP_BGTZ: take = !a[31] && (a != 32'd0);
      OP_ADDI, OP_ADDIU: begin
        wr = 1'b1; wreg = rt; wval = a + simm;
      end
      OP_SLTI: begin
        wr = 1'b1; wreg = rt; wval = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin
        wr = 1'b1; wreg = rt; wval = {31'd0, a < simm};
      end
      OP_ANDI: begin
        wr = 1'b1; wreg = rt; wval = a & zimm;
      end
      OP_ORI: begin
        wr = 1'b1; wreg = rt; wval = a | zimm;
      end
      OP_XORI: begin
        wr = 1'b1; wreg = rt; wval = a ^ zimm;
      end
      OP_LUI: begin
        wr = 1'b1; wreg = rt; wval = {ins_q[15:0], 16'd0};
      end
      OP_LB, OP_LBU: begin
        wr = 1'b1; wreg = rt; wval = (rdata_q >> lsh) & 32'hFF;
        if (op == OP_LB) wval = {{24{wval[7]}}, wval[7:0]};
      end
      OP_LH, OP_LHU: begin
        wr = 1'b1; wreg = rt; wval = (rdata_q >> lsh) & 32'hFFFF;
        if (op == OP_LH) wval = {{16{wval[15]}}, wval[15:0]};
      end
      OP_LW: begin
        wr = 1'b1; wreg = rt; wval = rdata_q;
      end
      OP_LWL: begin
        wr = 1'b1; wreg = rt;
        wval = (b & (32'h00FF_FFFF >> lsh)) | (rdata_q << (5'd24 - lsh));
      end
      OP_LWR: begin
        wr = 1'b1; wreg = rt;
        wval = (b & ~(ALL_ONES >> lsh)) | (rdata_q >> lsh);
      end
      OP_SB: begin
        st = 1'b1; st_mask = 32'hFF << lsh;
      end
      OP_SH: begin
        st = 1'b1; st_mask = 32'hFFFF << lsh;
      end
      OP_SW: st = 1'b1;
      default: fault = FAULT_ILL;
    endcase
    if (misal) begin
      wr = 1'b0; st = 1'b0; fault = FAULT_ALIGN;
    end
    if (wreg == 5'd0) wr = 1'b0;
    if (!wr) begin
      wreg = 5'd0; wval = 32'd0;
    end
  end

  assign st_data = (rdata_q & ~st_mask) | ((b << lsh) & st_mask);
  assign npc     = bpend_q ? bdest_q : seq;

  // instruction completes in exec, at the muldiv finish, or after the memory access
  assign fin = ((state_q == ST_EXEC) && !is_md && !(is_mem && !misal)) ||
               ((state_q == ST_MDWAIT) && md_done) ||
               (state_q == ST_MEMWB);

  // muldiv requests: the instruction itself, or the word index modulo the memory size
  always_comb begin
    md_req = '0;
    md_a   = a;
    md_b   = b;
    if (state_q == ST_EXEC) begin
      if (is_md) begin
        md_req.start = 1'b1;
        md_req.div   = (fn == FN_DIV) || (fn == FN_DIVU);
        md_req.sgn   = (fn == FN_MULT) || (fn == FN_DIV);
      end else if (is_mem && !misal && !POW2) begin
        md_req.start = 1'b1;
        md_req.div   = 1'b1;
        md_a         = {2'b00, addr[31:2]};
        md_b         = 32'(DMEM_WORDS);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      bpend_q   <= 1'b0;
      bdest_q   <= '0;
      hi_q      <= '0;
      lo_q      <= '0;
      rf_vld_q  <= '0;
      ovld_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DMEM_WORDS - 1)) clr_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pc_q    <= {cfg_wdata_i[31:2], 2'b00};
        bpend_q <= 1'b0;
      end
      if ((state_q == ST_MDWAIT) && md_done) begin
        hi_q <= md_hi;
        lo_q <= md_lo;
      end
      if (fin) begin
        if (mthi) hi_q <= a;
        if (mtlo) lo_q <= a;
        if (wr) rf_vld_q[wreg] <= 1'b1;
        pc_q    <= npc;
        bpend_q <= take;
        if (take) bdest_q <= tgt;
        ovld_q  <= 1'b1;
      end else if (out_acc) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // register file, two read ports registered at accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ins_q  <= in_i.instr_word;
      rfa_q  <= rf[in_i.instr_word[25:21]];
      rfb_q  <= rf[in_i.instr_word[20:16]];
      vlda_q <= rf_vld_q[in_i.instr_word[25:21]];
      vldb_q <= rf_vld_q[in_i.instr_word[20:16]];
    end
    if (fin && wr) rf[wreg] <= wval;
  end

  // word index
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) idx_q <= addr[AW+1:2];
    else if ((state_q == ST_IDXWAIT) && md_done) idx_q <= md_hi[AW-1:0];
  end

  // data memory, one port each for write and read
  always_ff @(posedge clk_i) begin
    if (clr_q) dmem[clr_cnt_q] <= 32'd0;
    else if ((state_q == ST_MEMWB) && st) dmem[idx_q] <= st_data;
    rdata_q <= dmem[idx_q];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fin) begin
      onpc_q <= npc;
      owr_q  <= wr;
      oreg_q <= wreg;
      oval_q <= wval;
      ost_q  <= st;
      oflt_q <= fault;
    end
  end

  assign in_i.ready            = (state_q == ST_IDLE) && !clr_q;
  assign res_o.valid           = ovld_q;
  assign res_o.next_fetch_addr = onpc_q;
  assign res_o.reg_written     = owr_q;
  assign res_o.dest_index      = oreg_q;
  assign res_o.dest_value      = oval_q;
  assign res_o.store_done      = ost_q;
  assign res_o.fault_code      = oflt_q;

  `MIE_ASSERT_NOW(a_busy_excl, in_i.ready, !res_o.valid, "request taken while result pending")
  `MIE_ASSERT_NOW(a_clr_block, clr_q, !in_i.ready, "request taken during memory clear")
  `MIE_ASSERT_NEXT(a_ret_idle, out_acc && !clr_q, in_i.ready, "not idle after result taken")
  `MIE_ASSERT_NOW(a_no_r0, res_o.valid && res_o.reg_written, res_o.dest_index != 5'd0, "write to r0 reported")
  `MIE_ASSERT_NOW(a_fault_wr, res_o.valid && (res_o.fault_code != FAULT_NONE), !res_o.reg_written && !res_o.store_done, "faulting request wrote state")

endmodule
